### sv/dwmd_pkg.sv
// Shared types and constants for the dual wire message deframer.
// Holds the request classification record, codes and character constants.
// No dependencies.
package dwmd_pkg;

    localparam int PREFIX_LEN = 6;
    localparam int TAG_LEN    = 4;
    localparam int TGT_W      = 21;
    localparam int ACC_W      = 20;

    localparam logic [31:0] CMD_TAG       = "cmd=";
    localparam logic [7:0]  CH_NEWLINE    = 8'h0A;
    localparam logic [7:0]  CH_TAB        = 8'h09;
    localparam logic [7:0]  CH_CR         = 8'h0D;
    localparam logic [7:0]  CH_SPACE      = 8'h20;
    localparam logic [7:0]  CH_PLUS       = 8'h2B;
    localparam logic [7:0]  CH_MINUS      = 8'h2D;
    localparam logic [7:0]  CH_ZERO       = 8'h30;
    localparam logic [7:0]  CH_NINE       = 8'h39;
    localparam logic [15:0] MAX_LEN_RESET = 16'd1024;

    typedef enum logic [1:0] {
        VER_UNKNOWN,
        VER_NEWLINE,
        VER_LENGTH
    } t_version;

    typedef enum logic [1:0] {
        CAUSE_OPEN,
        CAUSE_DELIM,
        CAUSE_LIMIT,
        CAUSE_STREAM
    } t_cause;

    typedef enum logic [1:0] {
        PS_SKIP,
        PS_DIGITS,
        PS_STOP
    } t_parse;

    typedef struct packed {
        logic [7:0]         data;
        logic               stream_end;
        logic               is_blank;
        logic               is_sign;
        logic               is_minus;
        logic               is_digit;
        logic [3:0]         digit;
        logic               is_newline;
        logic [TAG_LEN-1:0] cmd_hit;
    } t_item;

endpackage

### sv/dwmd_front.sv
// Front end: accepts stream requests and classifies each byte.
// Depends on dwmd_pkg; feeds dwmd_queue.
module dwmd_front (
    input  logic           i_valid,
    input  logic [7:0]     i_data_byte,
    input  logic           i_stream_end,
    input  logic           i_full,
    output logic           o_ready,
    output logic           o_push,
    output dwmd_pkg::t_item o_item
);
    import dwmd_pkg::*;

    always_comb begin
        o_ready = !i_full;
        o_push  = i_valid && !i_full;

        o_item.data       = i_data_byte;
        o_item.stream_end = i_stream_end;
        o_item.is_blank   = (i_data_byte == CH_SPACE) ||
                            (i_data_byte >= CH_TAB && i_data_byte <= CH_CR);
        o_item.is_sign    = (i_data_byte == CH_PLUS) || (i_data_byte == CH_MINUS);
        o_item.is_minus   = (i_data_byte == CH_MINUS);
        o_item.is_digit   = (i_data_byte >= CH_ZERO) && (i_data_byte <= CH_NINE);
        o_item.digit      = 4'(i_data_byte - CH_ZERO);
        o_item.is_newline = (i_data_byte == CH_NEWLINE);
        for (int k = 0; k < TAG_LEN; k++) begin
            o_item.cmd_hit[k] = (i_data_byte == CMD_TAG[31-8*k -: 8]);
        end
    end

endmodule

### sv/dwmd_queue.sv
// Short request queue between the front and back ends.
// Depends on dwmd_pkg for the request record.
module dwmd_queue #(
    parameter int DEPTH = 2
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  dwmd_pkg::t_item i_item,
    output logic            o_full,
    output logic            o_valid,
    output dwmd_pkg::t_item o_item,
    input  logic            i_pop
);
    import dwmd_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_item          r_mem [DEPTH];
    logic [PW-1:0]  r_wr_ptr, r_rd_ptr, n_wr_ptr, n_rd_ptr;
    logic [CW-1:0]  r_count, n_count;

    always_comb begin
        o_full   = (r_count == CW'(DEPTH));
        o_valid  = (r_count != '0);
        o_item   = r_mem[r_rd_ptr];
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

### sv/dwmd_back.sv
// Back end: framing state, length decode and the registered result stage.
// Depends on dwmd_pkg; takes classified requests from dwmd_queue.
module dwmd_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_valid,
    input  logic [15:0]     i_max_len,
    input  logic            i_q_valid,
    input  dwmd_pkg::t_item i_q_item,
    output logic            o_pop,
    input  logic            i_ready,
    output logic            o_valid,
    output logic [7:0]      o_byte_out,
    output logic            o_byte_valid,
    output logic            o_last,
    output logic [1:0]      o_frame_version,
    output logic [1:0]      o_end_cause,
    output logic [15:0]     o_msg_length
);
    import dwmd_pkg::*;

    logic [15:0]       r_limit;
    logic [15:0]       r_count, n_count, cnt_inc;
    t_version          r_version, n_version;
    logic [TGT_W-1:0]  r_target, n_target, calc_target;
    logic [ACC_W-1:0]  r_acc, n_acc, acc_next;
    logic              r_neg, n_neg, r_cmd_ok, n_cmd_ok;
    t_parse            r_parse, n_parse;

    logic              r_out_valid, r_out_byte_valid, r_out_last;
    logic [7:0]        r_out_byte;
    t_version          r_out_version;
    t_cause            r_out_cause;
    logic [15:0]       r_out_len;

    logic              produce, at_six, len_hit, clear;
    t_cause            cause;
    t_version          res_version;
    logic [15:0]       res_len;
    logic [7:0]        res_byte;
    logic              res_byte_valid;
    logic [2:0]        idx;

    assign o_pop = i_q_valid && (!r_out_valid || i_ready);

    always_comb begin
        idx      = r_count[2:0];
        cnt_inc  = r_count + 16'd1;
        acc_next = {r_acc[ACC_W-4:0], 3'b000} + {r_acc[ACC_W-2:0], 1'b0}
                 + {{(ACC_W-4){1'b0}}, i_q_item.digit};
        n_parse  = r_parse;
        n_acc    = r_acc;
        n_neg    = r_neg;
        n_cmd_ok = r_cmd_ok;
        if (r_count < 16'(PREFIX_LEN)) begin
            if (r_count < 16'(TAG_LEN)) begin
                n_cmd_ok = r_cmd_ok && i_q_item.cmd_hit[idx[1:0]];
            end
            unique case (r_parse)
                PS_SKIP: begin
                    if (i_q_item.is_blank) begin
                        n_parse = PS_SKIP;
                    end else if (i_q_item.is_sign) begin
                        n_parse = PS_DIGITS;
                        n_neg   = i_q_item.is_minus;
                    end else if (i_q_item.is_digit) begin
                        n_parse = PS_DIGITS;
                        n_acc   = acc_next;
                    end else begin
                        n_parse = PS_STOP;
                    end
                end
                PS_DIGITS: begin
                    if (i_q_item.is_digit) begin
                        n_acc = acc_next;
                    end else begin
                        n_parse = PS_STOP;
                    end
                end
                PS_STOP: n_parse = PS_STOP;
                default: n_parse = PS_STOP;
            endcase
        end

        at_six      = (cnt_inc == 16'(PREFIX_LEN));
        calc_target = n_neg ? TGT_W'(PREFIX_LEN) - {1'b0, n_acc}
                            : {1'b0, n_acc} + TGT_W'(PREFIX_LEN);
        n_version   = r_version;
        n_target    = r_target;
        if (at_six) begin
            n_version = n_cmd_ok ? VER_NEWLINE : VER_LENGTH;
            n_target  = calc_target;
        end
        len_hit = at_six ? (n_acc == '0)
                         : ({{(TGT_W-16){1'b0}}, cnt_inc} == r_target);

        if (n_version == VER_NEWLINE && i_q_item.is_newline) begin
            cause = CAUSE_DELIM;
        end else if (n_version == VER_LENGTH && len_hit) begin
            cause = CAUSE_DELIM;
        end else if (cnt_inc >= r_limit) begin
            cause = CAUSE_LIMIT;
        end else begin
            cause = CAUSE_OPEN;
        end

        if (i_q_item.stream_end) begin
            produce        = (r_count != '0);
            clear          = 1'b1;
            res_byte       = '0;
            res_byte_valid = 1'b0;
            res_version    = r_version;
            res_len        = r_count;
            cause          = CAUSE_STREAM;
        end else begin
            produce        = 1'b1;
            clear          = (cause != CAUSE_OPEN);
            res_byte       = i_q_item.data;
            res_byte_valid = 1'b1;
            res_version    = n_version;
            res_len        = cnt_inc;
        end
        n_count = cnt_inc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_parse <= PS_SKIP;
        end else if (o_pop) begin
            r_parse <= clear ? PS_SKIP : n_parse;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit     <= MAX_LEN_RESET - 16'd1;
            r_count     <= '0;
            r_version   <= VER_UNKNOWN;
            r_target    <= '0;
            r_acc       <= '0;
            r_neg       <= 1'b0;
            r_cmd_ok    <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_limit <= (i_max_len < 16'd2) ? 16'd1 : i_max_len - 16'd1;
            end
            if (o_pop) begin
                if (clear) begin
                    r_count   <= '0;
                    r_version <= VER_UNKNOWN;
                    r_target  <= '0;
                    r_acc     <= '0;
                    r_neg     <= 1'b0;
                    r_cmd_ok  <= 1'b1;
                end else begin
                    r_count   <= n_count;
                    r_version <= n_version;
                    r_target  <= n_target;
                    r_acc     <= n_acc;
                    r_neg     <= n_neg;
                    r_cmd_ok  <= n_cmd_ok;
                end
            end
            if (o_pop && produce) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && produce) begin
            r_out_byte       <= res_byte;
            r_out_byte_valid <= res_byte_valid;
            r_out_last       <= clear;
            r_out_version    <= res_version;
            r_out_cause      <= cause;
            r_out_len        <= res_len;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_byte_out      = r_out_byte;
    assign o_byte_valid    = r_out_byte_valid;
    assign o_last          = r_out_last;
    assign o_frame_version = r_out_version;
    assign o_end_cause     = r_out_cause;
    assign o_msg_length    = r_out_len;

    a_open_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_last |-> r_out_cause == CAUSE_OPEN)
        else $error("open result carries an end cause");

    a_stream_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_byte_valid |-> r_out_last && r_out_cause == CAUSE_STREAM)
        else $error("byteless result is not a stream end closure");

    a_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out_len != 16'd0)
        else $error("result with zero message length");

    a_version_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_version == VER_UNKNOWN |-> r_out_len < 16'(PREFIX_LEN))
        else $error("version still unknown past the prefix");

endmodule

### sv/dual_wire_message_deframer_top.sv
// Top level of the dual wire message deframer.
// Instantiates dwmd_front, dwmd_queue and dwmd_back; uses dwmd_pkg.
//
// Takes one byte per cycle and returns one result per byte, back to back, while
// neither side stalls; a request flagged as stream end returns a closing result
// only when a message is open. Each request is classified as it is accepted,
// waits in a short queue, and is handled by the back end, whose framing state
// (count, version, decoded length) is the only loop; results leave through an
// output register.
// The configuration port is always ready and sets the message size limit.
module dual_wire_message_deframer_top #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_stream_end,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_byte_out,
    output logic        o_byte_valid,
    output logic        o_last,
    output logic [1:0]  o_frame_version,
    output logic [1:0]  o_end_cause,
    output logic [15:0] o_msg_length,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_max_len
);
    import dwmd_pkg::*;

    t_item front_item, q_item;
    logic  push, q_full, q_valid, pop;

    assign o_cfg_ready = 1'b1;

    dwmd_front u_front (
        .i_valid      (i_valid),
        .i_data_byte  (i_data_byte),
        .i_stream_end (i_stream_end),
        .i_full       (q_full),
        .o_ready      (o_ready),
        .o_push       (push),
        .o_item       (front_item)
    );

    dwmd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_item  (q_item),
        .i_pop   (pop)
    );

    dwmd_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .i_max_len       (i_max_len),
        .i_q_valid       (q_valid),
        .i_q_item        (q_item),
        .o_pop           (pop),
        .i_ready         (i_ready),
        .o_valid         (o_valid),
        .o_byte_out      (o_byte_out),
        .o_byte_valid    (o_byte_valid),
        .o_last          (o_last),
        .o_frame_version (o_frame_version),
        .o_end_cause     (o_end_cause),
        .o_msg_length    (o_msg_length)
    );

endmodule

### bench/testbench.sv
// Self-checking bench for dual_wire_message_deframer_top: directed table, then random framing.
// Depends on dwmd_pkg and the deframer RTL; predicts every result internally.
module testbench;
    import dwmd_pkg::*;

    typedef struct packed {
        logic [7:0]  byte_out;
        logic        byte_valid;
        logic        last;
        t_version    version;
        t_cause      cause;
        logic [15:0] length;
    } t_frame_out;

    typedef enum logic [1:0] {
        STEP_BYTE,
        STEP_END,
        STEP_LIMIT
    } t_step_kind;

    typedef struct packed {
        t_step_kind  kind;
        logic [15:0] value;
        logic        typed;
        t_frame_out  want;
    } t_step;

    localparam int DIRECTED_STEPS = 26;
    localparam t_step DIRECTED_PLAN [DIRECTED_STEPS] = '{
        '{STEP_END,   16'h0041, 1'b0, '0},
        '{STEP_BYTE,  16'h0020, 1'b1, '{8'h20, 1'b1, 1'b0, VER_UNKNOWN, CAUSE_OPEN, 16'd1}},
        '{STEP_BYTE,  16'h0009, 1'b0, '0},
        '{STEP_BYTE,  16'h002B, 1'b0, '0},
        '{STEP_BYTE,  16'h0030, 1'b0, '0},
        '{STEP_BYTE,  16'h0078, 1'b0, '0},
        '{STEP_BYTE,  16'h00FF, 1'b1, '{8'hFF, 1'b1, 1'b1, VER_LENGTH, CAUSE_DELIM, 16'd6}},
        '{STEP_BYTE,  16'h002D, 1'b0, '0},
        '{STEP_BYTE,  16'h0037, 1'b0, '0},
        '{STEP_BYTE,  16'h0000, 1'b0, '0},
        '{STEP_BYTE,  16'h000D, 1'b0, '0},
        '{STEP_BYTE,  16'h0041, 1'b0, '0},
        '{STEP_BYTE,  16'h000A, 1'b0, '0},
        '{STEP_END,   16'h005A, 1'b1, '{8'h00, 1'b0, 1'b1, VER_LENGTH, CAUSE_STREAM, 16'd6}},
        '{STEP_LIMIT, 16'd7,    1'b0, '0},
        '{STEP_BYTE,  16'h0063, 1'b0, '0},
        '{STEP_BYTE,  16'h006D, 1'b0, '0},
        '{STEP_BYTE,  16'h0064, 1'b0, '0},
        '{STEP_BYTE,  16'h003D, 1'b0, '0},
        '{STEP_BYTE,  16'h000A, 1'b0, '0},
        '{STEP_BYTE,  16'h000A, 1'b1, '{8'h0A, 1'b1, 1'b1, VER_NEWLINE, CAUSE_DELIM, 16'd6}},
        '{STEP_LIMIT, 16'd1,    1'b0, '0},
        '{STEP_BYTE,  16'h0080, 1'b1, '{8'h80, 1'b1, 1'b1, VER_UNKNOWN, CAUSE_LIMIT, 16'd1}},
        '{STEP_BYTE,  16'h007F, 1'b1, '{8'h7F, 1'b1, 1'b1, VER_UNKNOWN, CAUSE_LIMIT, 16'd1}},
        '{STEP_END,   16'h00C3, 1'b0, '0},
        '{STEP_LIMIT, 16'd1024, 1'b0, '0}
    };

    localparam logic [15:0] PHASE_LIMITS [5] = '{16'd65535, 16'd2, 16'd1024, 16'd40, 16'd16};

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [7:0]  i_data_byte;
    logic        i_stream_end;
    logic        o_valid;
    logic        i_ready;
    logic [7:0]  o_byte_out;
    logic        o_byte_valid;
    logic        o_last;
    logic [1:0]  o_frame_version;
    logic [1:0]  o_end_cause;
    logic [15:0] o_msg_length;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [15:0] i_max_len;

    logic [15:0]            size_limit = MAX_LEN_RESET;
    logic [15:0]            msg_count = '0;
    logic [47:0]            msg_prefix = '0;
    t_version               msg_version = VER_UNKNOWN;
    logic signed [TGT_W-1:0] msg_target = '0;

    t_frame_out pending_frames[$];
    int send_gap_pct = 36;
    int recv_gap_pct = 63;
    int mismatches = 0;
    int requests_sent = 0;
    int results_checked = 0;
    int limits_written = 0;
    int phase_results = 0;
    int closed_by [4] = '{0, 0, 0, 0};

    dual_wire_message_deframer_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_data_byte     (i_data_byte),
        .i_stream_end    (i_stream_end),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_byte_out      (o_byte_out),
        .o_byte_valid    (o_byte_valid),
        .o_last          (o_last),
        .o_frame_version (o_frame_version),
        .o_end_cause     (o_end_cause),
        .o_msg_length    (o_msg_length),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_max_len       (i_max_len)
    );

    always #10 i_clk = ~i_clk;

    function automatic int decode_prefix_length(input logic [47:0] p);
        int  i;
        bit  neg;
        int  v;
        i = 0;
        neg = 1'b0;
        v = 0;
        while (i < PREFIX_LEN && (p[i*8 +: 8] == CH_SPACE ||
               (p[i*8 +: 8] >= CH_TAB && p[i*8 +: 8] <= CH_CR)))
            i++;
        if (i < PREFIX_LEN && (p[i*8 +: 8] == CH_PLUS || p[i*8 +: 8] == CH_MINUS)) begin
            neg = p[i*8 +: 8] == CH_MINUS;
            i++;
        end
        while (i < PREFIX_LEN && p[i*8 +: 8] >= CH_ZERO && p[i*8 +: 8] <= CH_NINE) begin
            v = v * 10 + int'(p[i*8 +: 8] - CH_ZERO);
            i++;
        end
        return neg ? -v : v;
    endfunction

    function automatic void frame_byte(input logic [7:0] data, input logic closing,
                                       output bit produced, output t_frame_out res);
        int     lim;
        t_cause cause;
        produced = 1'b0;
        res = '0;
        lim = (size_limit < 16'd2) ? 2 : int'(size_limit);
        if (closing) begin
            if (msg_count == 0)
                return;
            res = '{8'h00, 1'b0, 1'b1, msg_version, CAUSE_STREAM, msg_count};
        end else begin
            if (msg_count < PREFIX_LEN)
                msg_prefix[msg_count*8 +: 8] = data;
            msg_count++;
            if (msg_count == PREFIX_LEN) begin
                if ({msg_prefix[7:0], msg_prefix[15:8], msg_prefix[23:16],
                     msg_prefix[31:24]} == CMD_TAG) begin
                    msg_version = VER_NEWLINE;
                end else begin
                    msg_version = VER_LENGTH;
                    msg_target = TGT_W'(decode_prefix_length(msg_prefix) + PREFIX_LEN);
                end
            end
            if (msg_version == VER_NEWLINE && data == CH_NEWLINE)
                cause = CAUSE_DELIM;
            else if (msg_version == VER_LENGTH && int'(msg_count) == int'(msg_target))
                cause = CAUSE_DELIM;
            else if (int'(msg_count) >= lim - 1)
                cause = CAUSE_LIMIT;
            else
                cause = CAUSE_OPEN;
            res = '{data, 1'b1, cause != CAUSE_OPEN, msg_version, cause, msg_count};
        end
        produced = 1'b1;
        if (res.last) begin
            msg_count = '0;
            msg_prefix = '0;
            msg_version = VER_UNKNOWN;
            msg_target = '0;
        end
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want) begin
            $error("%s expected %0h actual %0h", name, want, got);
            mismatches++;
        end
    endfunction

    task automatic send_request(input logic [7:0] data, input logic closing = 1'b0,
                                input bit typed = 1'b0, input t_frame_out want = '0);
        t_frame_out got;
        bit         produced;
        while ($urandom_range(99) < send_gap_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_data_byte <= data;
        i_stream_end <= closing;
        do @(posedge i_clk); while (!o_ready);
        frame_byte(data, closing, produced, got);
        requests_sent++;
        if (produced) begin
            pending_frames.push_back(typed ? want : got);
            phase_results++;
        end
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        while (pending_frames.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_max_len(input logic [15:0] value);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_max_len <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        size_limit = value;
        limits_written++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            i_ready <= ($urandom_range(99) >= recv_gap_pct);
        end
    end

    always @(posedge i_clk) begin : result_check
        t_frame_out want;
        if (i_rst_n && o_valid && i_ready) begin
            results_checked++;
            if (o_last)
                closed_by[o_end_cause]++;
            if (pending_frames.size() == 0) begin
                $error("result with no request pending: byte_out %0h", o_byte_out);
                mismatches++;
            end else begin
                want = pending_frames.pop_front();
                check_field("byte_out", 16'(want.byte_out), 16'(o_byte_out));
                check_field("byte_valid", 16'(want.byte_valid), 16'(o_byte_valid));
                check_field("last", 16'(want.last), 16'(o_last));
                check_field("frame_version", 16'(want.version), 16'(o_frame_version));
                check_field("end_cause", 16'(want.cause), 16'(o_end_cause));
                check_field("msg_length", want.length, o_msg_length);
            end
        end
    end

    initial begin
        #4000000;
        $display("Verification failed");
        $finish;
    end

    initial begin
        int         phase;
        int         choice;
        int         k;
        int         n;
        int         nb;
        int         val;
        int         pos;
        bit         big;
        bit         paused;
        logic [7:0] pre [PREFIX_LEN];
        string      digits;

        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data_byte = '0;
        i_stream_end = 1'b0;
        i_cfg_valid = 1'b0;
        i_max_len = MAX_LEN_RESET;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (k = 0; k < DIRECTED_STEPS; k++) begin
            case (DIRECTED_PLAN[k].kind)
                STEP_LIMIT: write_max_len(DIRECTED_PLAN[k].value);
                STEP_END: send_request(DIRECTED_PLAN[k].value[7:0], 1'b1,
                                       DIRECTED_PLAN[k].typed, DIRECTED_PLAN[k].want);
                default: send_request(DIRECTED_PLAN[k].value[7:0], 1'b0,
                                      DIRECTED_PLAN[k].typed, DIRECTED_PLAN[k].want);
            endcase
        end

        for (phase = 0; phase < 6; phase++) begin
            send_gap_pct = phase < 2 ? 36 : (phase < 4 ? 63 : 0);
            recv_gap_pct = phase < 2 ? 63 : (phase < 4 ? 36 : 0);
            write_max_len(phase == 5 ? 16'($urandom_range(7, 200)) : PHASE_LIMITS[phase]);
            phase_results = 0;
            paused = 1'b0;
            while (phase_results < 100) begin
                if (!paused && phase_results >= 50) begin
                    drain_results();
                    paused = 1'b1;
                end
                choice = $urandom_range(99);
                if (choice < 40) begin
                    for (k = 0; k < TAG_LEN; k++)
                        send_request(CMD_TAG[31-8*k -: 8]);
                    n = $urandom_range(0, 12);
                    for (k = 0; k < n; k++)
                        send_request(8'($urandom));
                    send_request(CH_NEWLINE);
                end else if (choice < 75) begin
                    big = ($urandom_range(7) == 0);
                    pos = 0;
                    nb = big ? 0 : $urandom_range(0, 2);
                    for (k = 0; k < nb; k++) begin
                        case ($urandom_range(3))
                            0: pre[pos] = CH_SPACE;
                            1: pre[pos] = CH_TAB;
                            2: pre[pos] = CH_CR;
                            default: pre[pos] = CH_NEWLINE;
                        endcase
                        pos++;
                    end
                    if (!big && $urandom_range(3) == 0) begin
                        pre[pos] = $urandom_range(1) ? CH_MINUS : CH_PLUS;
                        pos++;
                    end
                    val = big ? $urandom_range(10000, 999999) : $urandom_range(0, 24);
                    digits = $sformatf("%0d", val);
                    for (k = 0; k < digits.len(); k++) begin
                        pre[pos] = digits[k];
                        pos++;
                    end
                    while (pos < PREFIX_LEN) begin
                        pre[pos] = 8'($urandom);
                        pos++;
                    end
                    for (k = 0; k < PREFIX_LEN; k++)
                        send_request(pre[k]);
                    n = big ? $urandom_range(0, 20) : val;
                    for (k = 0; k < n; k++)
                        send_request(8'($urandom));
                end else if (choice < 88) begin
                    n = $urandom_range(1, 8);
                    for (k = 0; k < n; k++)
                        send_request(8'($urandom), $urandom_range(5) == 0);
                end else begin
                    n = $urandom_range(1, 5);
                    for (k = 0; k < n; k++)
                        send_request(k < TAG_LEN ? CMD_TAG[31-8*k -: 8] : 8'($urandom));
                    send_request(8'($urandom), 1'b1);
                end
                if (msg_count != 0 && (msg_count > 30 || $urandom_range(3) == 0))
                    send_request(8'($urandom), 1'b1);
            end
        end

        drain_results();
        $display("Sent %0d requests, checked %0d results across %0d size limit writes.",
                 requests_sent, results_checked, limits_written);
        $display("Messages closed by delimiter/length %0d, size limit %0d, stream end %0d.",
                 closed_by[CAUSE_DELIM], closed_by[CAUSE_LIMIT], closed_by[CAUSE_STREAM]);
        if (mismatches == 0 && pending_frames.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
